>>> src/sstq_pkg.sv
// Package: shared constants, types and helpers of the sorted timer queue.
`default_nettype none
package sstq_pkg;
    localparam int DEPTH_DEF    = 16;
    localparam int ID_BITS_DEF  = 16;
    localparam int TAG_BITS_DEF = 8;
    localparam int NOW_W        = 32;
    localparam int DLY_W        = 31;
    localparam int KIND_W       = 3;
    localparam int REM_W        = 5;
    localparam logic [31:0] WRAP_LIMIT = 32'h8000_0000;
    localparam logic [30:0] PERIODIC_BIT = 31'h4000_0000;

    typedef enum logic [1:0] {
        OP_ARM    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_QUERY  = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_ARMED   = 3'd0,
        K_FULL    = 3'd1,
        K_CANCEL  = 3'd2,
        K_QUERY   = 3'd3,
        K_FIRED   = 3'd4,
        K_TICK    = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CANCEL,
        S_WRAP,
        S_FIRE,
        S_REARM,
        S_EMIT
    } t_state;

    // Magnitude of a 31-bit signed delay, as a 32-bit unsigned value.
    function automatic logic [31:0] delay_mag(input logic [30:0] d);
        logic [31:0] r;
        r = {1'b0, d};
        if (d[30]) r = WRAP_LIMIT - r;
        return r;
    endfunction
endpackage
`default_nettype wire

>>> src/sstq_if.sv
// Interfaces: valid/ready channels for commands and results.
`default_nettype none
interface sstq_cmd_if #(
    parameter int ID_BITS  = sstq_pkg::ID_BITS_DEF,
    parameter int TAG_BITS = sstq_pkg::TAG_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [1:0]          op;
    logic [31:0]         now;
    logic signed [30:0]  delay;
    logic [ID_BITS-1:0]  handle_id;
    logic [ID_BITS:0]    handle_limit;
    logic [TAG_BITS-1:0] action_tag;
    modport source (output valid, op, now, delay, handle_id, handle_limit, action_tag,
                    input ready);
    modport sink (input valid, op, now, delay, handle_id, handle_limit, action_tag,
                  output ready);
endinterface

interface sstq_res_if #(
    parameter int ID_BITS  = sstq_pkg::ID_BITS_DEF,
    parameter int TAG_BITS = sstq_pkg::TAG_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [ID_BITS-1:0]  fired_id;
    logic [TAG_BITS-1:0] fired_action;
    logic                found;
    logic [4:0]          removed;
    logic                last;
    modport source (output valid, kind, fired_id, fired_action, found, removed, last,
                    input ready);
    modport sink (input valid, kind, fired_id, fired_action, found, removed, last,
                  output ready);
endinterface
`default_nettype wire

>>> src/sstq_front.sv
// Front end: two-entry command queue that accepts and holds transactions.
`default_nettype none
module sstq_front #(
    parameter int ID_BITS  = sstq_pkg::ID_BITS_DEF,
    parameter int TAG_BITS = sstq_pkg::TAG_BITS_DEF,
    parameter int CMD_W    = 2 + 32 + 31 + ID_BITS + ID_BITS + 1 + TAG_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    sstq_cmd_if.sink              cmd,
    input  wire logic             i_pop,
    output logic                  o_avail,
    output logic [CMD_W-1:0]      o_cmd
);
    logic [CMD_W-1:0] r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             push, pop;

    assign cmd.ready = (r_cnt != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign o_avail   = (r_cnt != 2'd0);
    assign pop       = i_pop && o_avail;
    assign o_cmd     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {cmd.op, cmd.now, cmd.delay, cmd.handle_id, cmd.handle_limit,
                          cmd.action_tag};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> src/sstq_back.sv
// Back end: sorted register chain of timers with its control sequencer.
`default_nettype none
module sstq_back #(
    parameter int DEPTH    = sstq_pkg::DEPTH_DEF,
    parameter int ID_BITS  = sstq_pkg::ID_BITS_DEF,
    parameter int TAG_BITS = sstq_pkg::TAG_BITS_DEF,
    parameter int CMD_W    = 2 + 32 + 31 + ID_BITS + ID_BITS + 1 + TAG_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_avail,
    input  wire logic [CMD_W-1:0] i_cmd,
    output logic             o_pop,
    sstq_res_if.source       res,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int CW = $clog2(DEPTH + 1);

    // Decoded fields of the command at the head of the queue.
    logic [1:0]          c_op;
    logic [31:0]         c_now;
    logic [30:0]         c_dly;
    logic [ID_BITS-1:0]  c_id;
    logic [ID_BITS:0]    c_lim;
    logic [TAG_BITS-1:0] c_tag;
    assign {c_op, c_now, c_dly, c_id, c_lim, c_tag} = i_cmd;

    // Timer chain, slot 0 is the earliest expiry.
    logic [31:0]         r_exp [DEPTH];
    logic [30:0]         r_pd  [DEPTH];
    logic [ID_BITS-1:0]  r_oid [DEPTH];
    logic [TAG_BITS-1:0] r_act [DEPTH];
    logic [CW-1:0]       r_cnt;
    logic [31:0]         r_last;

    sstq_pkg::t_state    r_st, n_st;
    logic [31:0]         r_now;
    logic [CW-1:0]       r_fires;
    logic [4:0]          r_rem;
    logic [30:0]         r_fpd;
    logic [ID_BITS-1:0]  r_fid;
    logic [TAG_BITS-1:0] r_fact;

    // Output register.
    logic                r_ov;
    logic [2:0]          r_kind;
    logic [ID_BITS-1:0]  r_oid_o;
    logic [TAG_BITS-1:0] r_oact;
    logic                r_found, r_olast;
    logic [4:0]          r_orem;

    assign res.valid        = r_ov;
    assign res.kind         = r_kind;
    assign res.fired_id     = r_oid_o;
    assign res.fired_action = r_oact;
    assign res.found        = r_found;
    assign res.removed      = r_orem;
    assign res.last         = r_olast;
    assign o_count          = r_cnt;

    logic out_free;
    assign out_free = !r_ov || res.ready;

    // Per-slot match vectors.
    logic [DEPTH-1:0] v_ok, m_cancel, m_query, gt_ins, m_wrap;
    logic [31:0]      ins_t;
    logic [30:0]      ins_pd;
    logic [ID_BITS-1:0]  ins_id;
    logic [TAG_BITS-1:0] ins_tag;
    logic [CW-1:0]    n_keep;
    logic             do_ins, do_pop, do_cancel, do_wrap;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            v_ok[i]     = (CW'(i) < r_cnt);
            m_cancel[i] = v_ok[i] && ({1'b0, r_oid[i]} >= {1'b0, c_id}) &&
                          ({1'b0, r_oid[i]} < c_lim);
            m_query[i]  = v_ok[i] && (r_oid[i] == c_id);
            gt_ins[i]   = v_ok[i] && (ins_t < r_exp[i]);
            m_wrap[i]   = v_ok[i] && (r_exp[i] > sstq_pkg::WRAP_LIMIT);
        end
    end

    // Cancel compacts one removal per cycle: find the first matching slot.
    logic [CW-1:0] first_m;
    always_comb begin
        first_m = CW'(DEPTH);
        for (int i = DEPTH - 1; i >= 0; i--)
            if (m_cancel[i]) first_m = CW'(i);
    end

    always_comb begin
        if (r_st == sstq_pkg::S_REARM) begin
            ins_t   = r_now + sstq_pkg::delay_mag(r_fpd);
            ins_pd  = r_fpd;
            ins_id  = r_fid;
            ins_tag = r_fact;
        end else begin
            ins_t   = c_now + sstq_pkg::delay_mag(c_dly);
            ins_pd  = c_dly;
            ins_id  = c_id;
            ins_tag = c_tag;
        end
    end

    // Control: next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            sstq_pkg::S_IDLE: begin
                if (i_avail && out_free) begin
                    priority case (sstq_pkg::t_op'(c_op))
                        sstq_pkg::OP_CANCEL: n_st = sstq_pkg::S_CANCEL;
                        sstq_pkg::OP_TICK:   n_st = sstq_pkg::S_WRAP;
                        default:             n_st = sstq_pkg::S_IDLE;
                    endcase
                end
            end
            sstq_pkg::S_CANCEL: if (m_cancel == '0 && out_free) n_st = sstq_pkg::S_IDLE;
            sstq_pkg::S_WRAP:   n_st = sstq_pkg::S_FIRE;
            sstq_pkg::S_FIRE: begin
                if (out_free) begin
                    if (r_fires < CW'(DEPTH) && r_cnt != '0 && r_exp[0] < r_now)
                        n_st = (r_pd[0] & sstq_pkg::PERIODIC_BIT) != '0 ?
                               sstq_pkg::S_REARM : sstq_pkg::S_FIRE;
                    else
                        n_st = sstq_pkg::S_IDLE;
                end
            end
            sstq_pkg::S_REARM:  n_st = sstq_pkg::S_FIRE;
            default:            n_st = sstq_pkg::S_IDLE;
        endcase
    end

    // Control: datapath strobes.
    always_comb begin
        do_ins    = 1'b0;
        do_pop    = 1'b0;
        do_cancel = 1'b0;
        do_wrap   = 1'b0;
        o_pop     = 1'b0;
        unique case (r_st)
            sstq_pkg::S_IDLE: begin
                if (i_avail && out_free) begin
                    o_pop  = (sstq_pkg::t_op'(c_op) != sstq_pkg::OP_CANCEL) &&
                             (sstq_pkg::t_op'(c_op) != sstq_pkg::OP_TICK);
                    do_ins = (sstq_pkg::t_op'(c_op) == sstq_pkg::OP_ARM) &&
                             (r_cnt < CW'(DEPTH));
                end
            end
            sstq_pkg::S_CANCEL: begin
                do_cancel = (m_cancel != '0);
                o_pop     = (m_cancel == '0) && out_free;
            end
            sstq_pkg::S_WRAP:  do_wrap = (r_last > r_now);
            sstq_pkg::S_FIRE: begin
                do_pop = out_free && r_fires < CW'(DEPTH) && r_cnt != '0 &&
                         r_exp[0] < r_now;
                o_pop  = out_free && !do_pop;
            end
            sstq_pkg::S_REARM: do_ins = 1'b1;
            default: ;
        endcase
    end

    // A new timer goes in front of the first slot, scanned from the head, that
    // expires later. After a wrap the chain may be out of order, so this is a
    // first-match search rather than a count of earlier slots.
    always_comb begin
        n_keep = r_cnt;
        for (int i = DEPTH - 1; i >= 0; i--)
            if (gt_ins[i]) n_keep = CW'(i);
    end

    // Timer chain update: each slot keeps its value, takes a neighbor's or the new timer, or is cleared on a wrap.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (do_ins) begin
                if (CW'(i) == n_keep) begin
                    r_exp[i] <= ins_t;
                    r_pd[i]  <= ins_pd;
                    r_oid[i] <= ins_id;
                    r_act[i] <= ins_tag;
                end else if (CW'(i) > n_keep && i > 0) begin
                    r_exp[i] <= r_exp[i-1];
                    r_pd[i]  <= r_pd[i-1];
                    r_oid[i] <= r_oid[i-1];
                    r_act[i] <= r_act[i-1];
                end
            end else if ((do_pop || (do_cancel && CW'(i) >= first_m)) && i < DEPTH - 1) begin
                r_exp[i] <= r_exp[i+1];
                r_pd[i]  <= r_pd[i+1];
                r_oid[i] <= r_oid[i+1];
                r_act[i] <= r_act[i+1];
            end else if (do_wrap && m_wrap[i]) begin
                r_exp[i] <= '0;
            end
        end
        if (r_st == sstq_pkg::S_FIRE && do_pop) begin
            r_fpd  <= r_pd[0];
            r_fid  <= r_oid[0];
            r_fact <= r_act[0];
        end
        if (r_st == sstq_pkg::S_IDLE) begin
            r_now <= c_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= sstq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_last  <= '0;
            r_ov    <= 1'b0;
            r_fires <= '0;
            r_rem   <= '0;
        end else begin
            r_st <= n_st;
            if (do_ins)                     r_cnt <= r_cnt + CW'(1);
            else if (do_pop || do_cancel)   r_cnt <= r_cnt - CW'(1);
            if (r_st == sstq_pkg::S_WRAP)   r_last <= r_now;
            if (r_st == sstq_pkg::S_IDLE) begin
                r_fires <= '0;
                r_rem   <= '0;
            end
            if (do_pop)    r_fires <= r_fires + CW'(1);
            if (do_cancel) r_rem   <= r_rem + 5'd1;
            if (res.ready) r_ov <= 1'b0;
            if (o_pop || do_pop) r_ov <= 1'b1;
        end
    end

    // Result fields, loaded with each emitted transaction.
    always_ff @(posedge i_clk) begin
        if (o_pop || do_pop) begin
            r_oid_o <= '0;
            r_oact  <= '0;
            r_found <= 1'b0;
            r_orem  <= '0;
            r_olast <= 1'b1;
            if (do_pop) begin
                r_kind  <= sstq_pkg::K_FIRED;
                r_oid_o <= r_oid[0];
                r_oact  <= r_act[0];
                r_olast <= 1'b0;
            end else begin
                unique case (sstq_pkg::t_op'(c_op))
                    sstq_pkg::OP_ARM:
                        r_kind <= (r_cnt < CW'(DEPTH)) ? sstq_pkg::K_ARMED : sstq_pkg::K_FULL;
                    sstq_pkg::OP_CANCEL: begin
                        r_kind <= sstq_pkg::K_CANCEL;
                        r_orem <= r_rem;
                    end
                    sstq_pkg::OP_QUERY: begin
                        r_kind  <= sstq_pkg::K_QUERY;
                        r_found <= (m_query != '0);
                    end
                    sstq_pkg::OP_TICK: r_kind <= sstq_pkg::K_TICK;
                    default:           r_kind <= sstq_pkg::K_TICK;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> src/sorted_software_timer_queue_core.sv
// Top level of the sorted timer queue: command queue feeding the timer chain.
//
//  Channel | Direction | Payload
//  cmd     | in        | op, now, delay, handle_id, handle_limit, action_tag
//  res     | out       | kind, fired_id, fired_action, found, removed, last
//
// Arm and query finish in the back end's idle state. Cancel removes matching
// timers one at a time, and a tick checks for a wrap, then fires due timers one
// at a time with a rearm per periodic one; the chain's single update port sets this.
// Reset is synchronous and active low; it empties the queue and chain.
// A two-entry command queue keeps accepting transactions while a result
// waits in the output register, and the back end holds when that register is
// full and not taken.
`default_nettype none
module sorted_software_timer_queue_core #(
    parameter int DEPTH    = sstq_pkg::DEPTH_DEF,
    parameter int ID_BITS  = sstq_pkg::ID_BITS_DEF,
    parameter int TAG_BITS = sstq_pkg::TAG_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sstq_cmd_if.sink   cmd,
    sstq_res_if.source res
);
    localparam int CMD_W = 2 + 32 + 31 + ID_BITS + ID_BITS + 1 + TAG_BITS;
    localparam int CW    = $clog2(DEPTH + 1);

    logic             avail, pop;
    logic [CMD_W-1:0] head;
    logic [CW-1:0]    count;

    sstq_front #(.ID_BITS(ID_BITS), .TAG_BITS(TAG_BITS), .CMD_W(CMD_W)) u_front (
        .i_clk, .i_rst_n, .cmd,
        .i_pop(pop), .o_avail(avail), .o_cmd(head)
    );

    sstq_back #(.DEPTH(DEPTH), .ID_BITS(ID_BITS), .TAG_BITS(TAG_BITS),
                .CMD_W(CMD_W)) u_back (
        .i_clk, .i_rst_n, .i_avail(avail), .i_cmd(head), .o_pop(pop), .res,
        .o_count(count)
    );

    // The number of held timers never exceeds the chain depth.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(DEPTH)) else $error("timer count above depth");

    // Every command retired from the queue produces a result in the next cycle.
    a_pop_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> res.valid) else $error("retired command without result");

    // Fired results are never marked last.
    a_fire_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && res.kind == sstq_pkg::K_FIRED |-> !res.last)
        else $error("fired result marked last");
endmodule
`default_nettype wire
